// ===== hdl/fdc_pkg.sv =====
`default_nettype none

package fdc_pkg;

	typedef struct packed {
		logic       is_write;
		logic [9:0] addr;
		logic [7:0] wbyte;
	} req_t;

	typedef struct packed {
		logic [7:0] rbyte;
		logic       irq;
	} resp_t;

	localparam logic [9:0] PORT_DOR     = 10'h3F2;
	localparam logic [9:0] PORT_MSR     = 10'h3F4;
	localparam logic [9:0] PORT_DATA    = 10'h3F5;
	localparam logic [9:0] PORT_SCRATCH = 10'h3F9;

	localparam logic [7:0] CMD_SPECIFY = 8'h03;
	localparam logic [7:0] CMD_RECAL   = 8'h07;
	localparam logic [7:0] CMD_SENSE   = 8'h08;

	localparam logic [7:0] MSR_RQM  = 8'h80;
	localparam logic [7:0] MSR_DIO  = 8'h40;
	localparam logic [7:0] MSR_BUSY = 8'h10;

	localparam logic [7:0] ST0_RESET   = 8'hC0;
	localparam logic [7:0] ST0_INVALID = 8'h20;
	localparam logic [7:0] ST1_NONE    = 8'h00;

	localparam int         DOR_RESET_BIT = 2;
	localparam logic [1:0] CMD_CNT_MAX   = 2'd3;

endpackage

`default_nettype wire

// ===== hdl/fdc_regs.sv =====
`default_nettype none

module fdc_regs import fdc_pkg::*; #(
	parameter int RESULT_DEPTH = 4
) (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   en,
	input  req_t  req,
	output resp_t resp
);

	localparam int CW = $clog2(RESULT_DEPTH + 1);
	localparam logic [CW:0] DEPTH_W = (CW + 1)'(RESULT_DEPTH);

	logic          busy_q;
	logic          dor_rst_q;
	logic          rst_pend_q;
	logic [7:0]    scratch_q;
	logic [7:0]    first_q;
	logic [1:0]    cmd_cnt_q;
	logic [CW-1:0] res_cnt_q;
	logic [7:0]    queue_q [RESULT_DEPTH];

	logic          busy_n;
	logic          dor_rst_n;
	logic          rst_pend_n;
	logic [7:0]    scratch_n;
	logic [7:0]    first_n;
	logic [1:0]    cmd_cnt_n;
	logic [CW-1:0] res_cnt_n;
	logic [7:0]    queue_n [RESULT_DEPTH];

	logic [7:0]    first_eff;
	logic [1:0]    cnt_inc;
	logic [CW:0]   cnt_w;
	logic [CW:0]   cnt_w1;
	logic          push0_ok;
	logic          push1_ok;
	logic [7:0]    st0;

	always_comb begin
		busy_n     = busy_q;
		dor_rst_n  = dor_rst_q;
		rst_pend_n = rst_pend_q;
		scratch_n  = scratch_q;
		first_n    = first_q;
		cmd_cnt_n  = cmd_cnt_q;
		res_cnt_n  = res_cnt_q;
		queue_n    = queue_q;
		resp.rbyte = 8'h00;
		resp.irq   = 1'b0;

		cnt_w     = {1'b0, res_cnt_q};
		cnt_w1    = cnt_w + 1'b1;
		push0_ok  = cnt_w < DEPTH_W;
		push1_ok  = cnt_w1 < DEPTH_W;
		st0       = rst_pend_q ? ST0_RESET : ST0_INVALID;
		first_eff = (cmd_cnt_q == 2'd0) ? req.wbyte : first_q;
		cnt_inc   = (cmd_cnt_q < CMD_CNT_MAX) ? cmd_cnt_q + 2'd1 : CMD_CNT_MAX;

		if (req.is_write) begin
			case (req.addr)
				PORT_SCRATCH: scratch_n = req.wbyte;
				PORT_DOR: begin
					dor_rst_n = req.wbyte[DOR_RESET_BIT];
					if (req.wbyte[DOR_RESET_BIT] && !dor_rst_q) begin
						resp.irq   = 1'b1;
						rst_pend_n = 1'b1;
						busy_n     = 1'b0;
						cmd_cnt_n  = 2'd0;
						res_cnt_n  = '0;
					end
				end
				PORT_DATA: begin
					if (cmd_cnt_q == 2'd0) begin
						first_n = req.wbyte;
						busy_n  = 1'b1;
					end
					cmd_cnt_n = cnt_inc;
					if (first_eff == CMD_RECAL && cnt_inc == 2'd2) begin
						resp.irq  = 1'b1;
						cmd_cnt_n = 2'd0;
						busy_n    = 1'b0;
					end else if (first_eff == CMD_SPECIFY && cnt_inc == 2'd3) begin
						cmd_cnt_n = 2'd0;
						busy_n    = 1'b0;
					end else if (first_eff == CMD_SENSE && cnt_inc == 2'd1) begin
						cmd_cnt_n  = 2'd0;
						rst_pend_n = 1'b0;
						for (int i = 0; i < RESULT_DEPTH; i++) begin
							if (push0_ok && cnt_w == (CW + 1)'(i))
								queue_n[i] = st0;
							if (push1_ok && cnt_w1 == (CW + 1)'(i))
								queue_n[i] = ST1_NONE;
						end
						res_cnt_n = CW'(cnt_w + {{CW{1'b0}}, push0_ok}
							+ {{CW{1'b0}}, push1_ok});
					end
				end
				default: ;
			endcase
		end else begin
			case (req.addr)
				PORT_SCRATCH: resp.rbyte = scratch_q;
				PORT_MSR: resp.rbyte = MSR_RQM | (busy_q ? MSR_BUSY : 8'h00)
					| ((res_cnt_q != '0) ? MSR_DIO : 8'h00);
				PORT_DATA: begin
					if (res_cnt_q != '0) begin
						resp.rbyte = queue_q[0];
						for (int i = 0; i < RESULT_DEPTH - 1; i++)
							queue_n[i] = queue_q[i + 1];
						res_cnt_n = res_cnt_q - 1'b1;
					end
					if (res_cnt_q <= CW'(1))
						busy_n = 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			dor_rst_q  <= 1'b1;
			rst_pend_q <= 1'b0;
			scratch_q  <= 8'h00;
			cmd_cnt_q  <= 2'd0;
			res_cnt_q  <= '0;
		end else if (en) begin
			busy_q     <= busy_n;
			dor_rst_q  <= dor_rst_n;
			rst_pend_q <= rst_pend_n;
			scratch_q  <= scratch_n;
			cmd_cnt_q  <= cmd_cnt_n;
			res_cnt_q  <= res_cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			first_q <= first_n;
			queue_q <= queue_n;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, res_cnt_q} <= DEPTH_W)
		else $error("result count beyond queue depth");

	a_reset_clears: assert property (@(posedge clk) disable iff (!arst_n)
		en && req.is_write && req.addr == PORT_DOR && req.wbyte[DOR_RESET_BIT] && !dor_rst_q
		|=> res_cnt_q == '0 && cmd_cnt_q == 2'd0 && rst_pend_q && !busy_q)
		else $error("controller reset did not clear queues");

	a_first_busy: assert property (@(posedge clk) disable iff (!arst_n)
		en && req.is_write && req.addr == PORT_DATA && cmd_cnt_q == 2'd0
		&& req.wbyte != CMD_RECAL && req.wbyte != CMD_SPECIFY |=> busy_q)
		else $error("first command byte did not set busy");

endmodule

`default_nettype wire

// ===== hdl/floppy_controller_register_stub.sv =====
`default_nettype none
// An accepted request passes through the input stage and then the result register.
// Throughput: one request per cycle while m_tready is high; the register decode and
// queue update sit between the input stage and the result register.
// Reset: arst_n asynchronous, active low; clears control state, status, counts
// and scratch byte; queue contents and command byte are left unset.

module floppy_controller_register_stub import fdc_pkg::*; #(
	parameter int RESULT_DEPTH = 4
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,  // port_addr[9:0], write_byte[17:10], zero[23:18]
	input  wire  [0:0]  s_tuser,  // req_type[0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata   // read_byte[7:0], irq_raise[8], zero[15:9]
);

	logic  valid_s1;
	req_t  req_s1;
	logic  out_valid_q;
	resp_t resp_q;
	resp_t resp;
	logic  adv;
	logic  take;

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign take     = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, resp_q.irq, resp_q.rbyte};

	fdc_regs #(
		.RESULT_DEPTH(RESULT_DEPTH)
	) u_regs (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (adv),
		.req   (req_s1),
		.resp  (resp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1.is_write <= s_tuser[0];
			req_s1.addr     <= s_tdata[9:0];
			req_s1.wbyte    <= s_tdata[17:10];
		end
		if (adv)
			resp_q <= resp;
	end

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_valid_q |=> out_valid_q)
		else $error("pending request did not reach result register");

	a_hold_stage: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_tready |=> valid_s1 && $stable(req_s1))
		else $error("stalled request lost from input stage");

endmodule

`default_nettype wire
